@@ hw/rtl/bblc_pkg.sv @@
// Shared constants and command codes for the byte-budget LRU tile cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bblc_pkg;
    localparam int ENTRIES = 64;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CW      = IW + 1;
    localparam int KEY_W   = 61;
    localparam int BYTES_W = 28;
    localparam int TOTAL_W = 34;
    localparam int EVC_W   = 7;

    typedef enum logic [2:0] {
        CMD_GET      = 3'd0,
        CMD_PUT      = 3'd1,
        CMD_CONTAINS = 3'd2,
        CMD_EVICT    = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;
endpackage
`default_nettype wire

@@ hw/rtl/byte_budget_lru_tile_cache_unit.sv @@
// Byte-budget LRU tile cache: top level with table memories and sequencer.
// Depends on bblc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One command is taken at a time. Get, contains and put first scan every slot's key
// through one key memory port. Recency is a doubly linked list with head and tail
// pointers; each removal or move of an entry reads, then writes the link memories.
// A put drops a matching entry, then checks the budget before each further eviction
// and before it inserts; a get hit that is not already most recent is relinked at
// the head. Evict checks the total against the target before each removal and once
// more; clear, unknown commands and puts with a zero handle go straight to the
// result. The result is then held until taken; the input is not ready meanwhile.
module byte_budget_lru_tile_cache_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [31:0]                   i_max_bytes,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_command,
    input  wire logic [7:0]                    i_scheme_id,
    input  wire logic [4:0]                    i_zoom,
    input  wire logic [23:0]                   i_tile_x,
    input  wire logic [23:0]                   i_tile_y,
    input  wire logic [31:0]                   i_texture_handle,
    input  wire logic [12:0]                   i_tex_width,
    input  wire logic [12:0]                   i_tex_height,
    input  wire logic [31:0]                   i_target_bytes,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_hit,
    output logic [31:0]                        o_handle_out,
    output logic [bblc_pkg::TOTAL_W-1:0]       o_total_bytes_out,
    output logic [bblc_pkg::EVC_W-1:0]         o_evicted_count
);
    import bblc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_SDONE = 9'b000000100,
        ST_RMRD  = 9'b000001000,
        ST_RMWR  = 9'b000010000,
        ST_BUD   = 9'b000100000,
        ST_EVC   = 9'b001000000,
        ST_INS   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [31:0]          r_max;
    logic [2:0]           r_cmd;
    logic [KEY_W-1:0]     r_key;
    logic [31:0]          r_handle;
    logic [BYTES_W-1:0]   r_bytes;
    logic [31:0]          r_target;
    logic [ENTRIES-1:0]   r_valid;
    logic [TOTAL_W-1:0]   r_total;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_head, r_tail, r_sel, r_free;
    logic                 r_free_ok, r_found, r_chk;
    logic [CW-1:0]        r_idx;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_hit;
    logic [31:0]          r_hout;
    logic [EVC_W-1:0]     r_evc;

    logic [KEY_W-1:0]     r_mem_key    [ENTRIES];
    logic [31:0]          r_mem_handle [ENTRIES];
    logic [BYTES_W-1:0]   r_mem_bytes  [ENTRIES];
    logic [IW-1:0]        r_mem_prev   [ENTRIES];
    logic [IW-1:0]        r_mem_next   [ENTRIES];
    logic [KEY_W-1:0]     r_rd_key;
    logic [31:0]          r_rd_handle;
    logic [BYTES_W-1:0]   r_rd_bytes;
    logic [IW-1:0]        r_rd_prev, r_rd_next;

    logic                 w_touch, w_is_head, w_is_tail, w_unlink, w_match;
    logic                 w_over, w_full, w_empty, w_ev_more;
    logic [IW-1:0]        w_ins_slot;
    logic                 w_ent_we, w_next_we, w_prev_we;
    logic [IW-1:0]        w_next_addr, w_prev_addr, w_next_data, w_prev_data;
    logic [TOTAL_W:0]     w_sum;
    logic [25:0]          w_area;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = (r_state == ST_DONE);
    assign o_hit             = r_hit;
    assign o_handle_out      = r_hout;
    assign o_total_bytes_out = r_total;
    assign o_evicted_count   = r_evc;

    assign w_area     = 26'(i_tex_width) * 26'(i_tex_height);
    assign w_touch    = (r_cmd == CMD_GET);
    assign w_is_head  = (r_sel == r_head);
    assign w_is_tail  = (r_sel == r_tail);
    assign w_unlink   = (r_state == ST_RMWR) && !(w_touch && w_is_head);
    assign w_match    = r_chk && (r_rd_key == r_key);
    assign w_empty    = (r_count == '0);
    assign w_sum      = {1'b0, r_total} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, r_bytes};
    assign w_over     = (w_sum > {{(TOTAL_W + 1 - 32){1'b0}}, r_max}) && !w_empty;
    assign w_full     = (r_count == CW'(ENTRIES));
    assign w_ev_more  = (r_total > {{(TOTAL_W - 32){1'b0}}, r_target}) && !w_empty;
    assign w_ins_slot = w_touch ? r_sel : r_free;

    always_comb begin
        w_ent_we    = (r_state == ST_INS) && !w_touch;
        w_next_we   = 1'b0;
        w_prev_we   = 1'b0;
        w_next_addr = r_rd_prev;
        w_next_data = r_rd_next;
        w_prev_addr = r_rd_next;
        w_prev_data = r_rd_prev;
        if (w_unlink) begin
            w_next_we = !w_is_head;
            w_prev_we = !w_is_tail;
        end else if (r_state == ST_INS) begin
            w_next_we   = 1'b1;
            w_next_addr = w_ins_slot;
            w_next_data = r_head;
            w_prev_we   = !w_empty;
            w_prev_addr = r_head;
            w_prev_data = w_ins_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_mem_key[w_ins_slot]    <= r_key;
            r_mem_handle[w_ins_slot] <= r_handle;
            r_mem_bytes[w_ins_slot]  <= r_bytes;
        end
        if (w_next_we) r_mem_next[w_next_addr] <= w_next_data;
        if (w_prev_we) r_mem_prev[w_prev_addr] <= w_prev_data;
        r_rd_key    <= r_mem_key[r_idx[IW-1:0]];
        r_rd_handle <= r_mem_handle[r_sel];
        r_rd_bytes  <= r_mem_bytes[r_sel];
        r_rd_prev   <= r_mem_prev[r_sel];
        r_rd_next   <= r_mem_next[r_sel];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    priority case (i_command)
                        CMD_GET, CMD_CONTAINS: n_state = ST_SCAN;
                        CMD_PUT: n_state = (i_texture_handle != '0) ? ST_SCAN : ST_DONE;
                        CMD_EVICT: n_state = ST_EVC;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: if (r_idx == CW'(ENTRIES)) n_state = ST_SDONE;
            ST_SDONE: begin
                priority if (r_cmd == CMD_CONTAINS) n_state = ST_DONE;
                else if (r_found) n_state = ST_RMRD;
                else if (r_cmd == CMD_PUT) n_state = ST_BUD;
                else n_state = ST_DONE;
            end
            ST_RMRD: n_state = ST_RMWR;
            ST_RMWR: begin
                priority if (w_touch) n_state = w_is_head ? ST_DONE : ST_INS;
                else if (r_cmd == CMD_PUT) n_state = ST_BUD;
                else n_state = ST_EVC;
            end
            ST_BUD: n_state = (w_over || w_full) ? ST_RMRD : ST_INS;
            ST_EVC: n_state = w_ev_more ? ST_RMRD : ST_DONE;
            ST_INS: n_state = ST_DONE;
            ST_DONE: if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max   <= 32'd268435456;
            r_valid <= '0;
            r_total <= '0;
            r_count <= '0;
            r_hit   <= 1'b0;
            r_hout  <= '0;
            r_evc   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_max <= i_max_bytes;
            unique case (r_state)
                ST_IDLE: begin
                    r_cmd     <= i_command;
                    r_key     <= {i_scheme_id, i_zoom, i_tile_x, i_tile_y};
                    r_handle  <= i_texture_handle;
                    r_bytes   <= {w_area, 2'b00};
                    r_target  <= i_target_bytes;
                    r_idx     <= '0;
                    r_chk     <= 1'b0;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_hit     <= 1'b0;
                    r_hout    <= '0;
                    r_evc     <= '0;
                    if (i_valid && i_command == CMD_CLEAR) begin
                        r_valid <= '0;
                        r_total <= '0;
                        r_count <= '0;
                    end
                end
                ST_SCAN: begin
                    r_idx     <= r_idx + 1'b1;
                    r_cmp_idx <= r_idx[IW-1:0];
                    r_chk     <= (r_idx != CW'(ENTRIES)) && r_valid[r_idx[IW-1:0]];
                    if (r_idx != CW'(ENTRIES) && !r_valid[r_idx[IW-1:0]] && !r_free_ok) begin
                        r_free    <= r_idx[IW-1:0];
                        r_free_ok <= 1'b1;
                    end
                    if (w_match) begin
                        r_found <= 1'b1;
                        r_sel   <= r_cmp_idx;
                    end
                end
                ST_SDONE: begin
                    if (r_cmd == CMD_CONTAINS) r_hit <= r_found;
                end
                ST_RMWR: begin
                    if (w_touch) begin
                        r_hit  <= 1'b1;
                        r_hout <= r_rd_handle;
                    end else begin
                        r_valid[r_sel] <= 1'b0;
                        r_total   <= r_total - {{(TOTAL_W - BYTES_W){1'b0}}, r_rd_bytes};
                        r_count   <= r_count - 1'b1;
                        r_evc     <= r_evc + 1'b1;
                        r_free    <= r_sel;
                        r_free_ok <= 1'b1;
                    end
                    if (w_unlink) begin
                        if (w_is_head) r_head <= r_rd_next;
                        if (w_is_tail) r_tail <= r_rd_prev;
                    end
                end
                ST_BUD: if (w_over || w_full) r_sel <= r_tail;
                ST_EVC: if (w_ev_more) r_sel <= r_tail;
                ST_INS: begin
                    r_head <= w_ins_slot;
                    if (!w_touch) begin
                        if (w_empty) r_tail <= w_ins_slot;
                        r_valid[w_ins_slot] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_total <= w_sum[TOTAL_W-1:0];
                    end
                end
                ST_RMRD, ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/bblc_checker.sv @@
// Port-level checks for the tile cache top level, with its bind.
// Depends on bblc_pkg and byte_budget_lru_tile_cache_unit.
`timescale 1ns / 1ps
`default_nettype none
module bblc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_ready,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_hit,
    input wire logic [31:0]                   o_handle_out,
    input wire logic [bblc_pkg::TOTAL_W-1:0]  o_total_bytes_out,
    input wire logic [bblc_pkg::EVC_W-1:0]    o_evicted_count
);
    import bblc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_total_bytes_out))
        else $error("result beat dropped or changed while stalled");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after an accepted beat");
    a_handle_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_handle_out != '0) |-> o_hit)
        else $error("handle returned without a hit");
    a_evc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_evicted_count <= EVC_W'(ENTRIES)))
        else $error("evicted count exceeds table size");
endmodule

bind byte_budget_lru_tile_cache_unit bblc_checker u_bblc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit), .o_handle_out(o_handle_out),
    .o_total_bytes_out(o_total_bytes_out), .o_evicted_count(o_evicted_count)
);
`default_nettype wire

@@ sim/tb_byte_budget_lru_tile_cache_unit.sv @@
// Testbench for the byte-budget LRU tile cache: a directed table, a fill past capacity,
// then random commands, each result checked on a behavioural model of table and recency.
// Depends on bblc_pkg and byte_budget_lru_tile_cache_unit.
`timescale 1ns / 1ps
module tb_byte_budget_lru_tile_cache_unit;
    import bblc_pkg::*;

    localparam int N_RAND   = 850;
    localparam int LIMIT    = 2000000;
    localparam int TAIL_OFF = 120;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  sch;
        logic [4:0]  zm;
        logic [23:0] tx;
        logic [23:0] ty;
        logic [31:0] hnd;
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] tgt;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] hnd;
        logic [33:0] total;
        logic [6:0]  evc;
    } t_rsp;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [31:0] i_max_bytes = '0;
    logic i_valid = 0, o_ready, o_valid, i_ready = 0;
    t_req req = '0;
    logic o_hit;
    logic [31:0] o_handle_out;
    logic [TOTAL_W-1:0] o_total_bytes_out;
    logic [EVC_W-1:0] o_evicted_count;

    always #6 i_clk = ~i_clk;

    byte_budget_lru_tile_cache_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_max_bytes(i_max_bytes),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(req.cmd), .i_scheme_id(req.sch), .i_zoom(req.zm),
        .i_tile_x(req.tx), .i_tile_y(req.ty), .i_texture_handle(req.hnd),
        .i_tex_width(req.w), .i_tex_height(req.h), .i_target_bytes(req.tgt),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hit(o_hit), .o_handle_out(o_handle_out),
        .o_total_bytes_out(o_total_bytes_out), .o_evicted_count(o_evicted_count)
    );

    // cache model
    bit          m_valid [ENTRIES];
    logic [60:0] m_key   [ENTRIES];
    logic [31:0] m_hnd   [ENTRIES];
    logic [27:0] m_bytes [ENTRIES];
    int          m_rank  [ENTRIES];
    logic [33:0] m_total;
    logic [31:0] m_budget;

    t_rsp expected_rsp[$];
    int   errors, results, cycles;
    bit   no_idle;
    int   n_put, n_hit, n_evicted;

    function automatic int find_tile(logic [60:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int oldest_tile();
        int b;
        b = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && (b < 0 || m_rank[i] > m_rank[b])) b = i;
        return b;
    endfunction

    function automatic void drop_tile(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] > m_rank[s]) m_rank[i]--;
        m_valid[s] = 0;
        m_total = m_total - m_bytes[s];
    endfunction

    function automatic t_rsp predict_cache(t_req r);
        t_rsp o;
        logic [60:0] k;
        logic [33:0] nb;
        int s, v, lr;
        o = '0;
        k = {r.sch, r.zm, r.tx, r.ty};
        case (r.cmd)
            CMD_GET: begin
                s = find_tile(k);
                if (s >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (m_valid[i] && m_rank[i] < m_rank[s]) m_rank[i]++;
                    m_rank[s] = 0;
                    o.hit = 1;
                    o.hnd = m_hnd[s];
                end
            end
            CMD_PUT: if (r.hnd != 0) begin
                nb = 34'(r.w) * 34'(r.h) * 34'd4;
                s = find_tile(k);
                if (s >= 0) begin drop_tile(s); o.evc++; end
                lr = oldest_tile();
                while (m_total + nb > {2'b0, m_budget} && lr >= 0) begin
                    drop_tile(lr); o.evc++; lr = oldest_tile();
                end
                v = 0;
                for (int i = 0; i < ENTRIES; i++) v += m_valid[i];
                if (v >= ENTRIES) begin drop_tile(oldest_tile()); o.evc++; end
                for (int i = 0; i < ENTRIES; i++) if (m_valid[i]) m_rank[i]++;
                for (int i = 0; i < ENTRIES; i++)
                    if (!m_valid[i]) begin
                        m_valid[i] = 1; m_key[i] = k; m_hnd[i] = r.hnd;
                        m_bytes[i] = nb[27:0]; m_rank[i] = 0;
                        m_total = m_total + nb;
                        break;
                    end
            end
            CMD_CONTAINS: o.hit = find_tile(k) >= 0;
            CMD_EVICT: begin
                lr = oldest_tile();
                while (m_total > {2'b0, r.tgt} && lr >= 0) begin
                    drop_tile(lr); o.evc++; lr = oldest_tile();
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) m_valid[i] = 0;
                m_total = '0;
            end
            default: ;
        endcase
        o.total = m_total;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results);
        errors++;
    endtask

    // result side
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (o_valid && i_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("unexpected result beat %0d", results);
                errors++;
            end else begin
                t_rsp e;
                e = expected_rsp.pop_front();
                if (o_hit !== e.hit) report_mismatch("hit", o_hit, e.hit);
                if (o_handle_out !== e.hnd) report_mismatch("handle", o_handle_out, e.hnd);
                if (o_total_bytes_out !== e.total)
                    report_mismatch("total", o_total_bytes_out, e.total);
                if (o_evicted_count !== e.evc)
                    report_mismatch("evicted", o_evicted_count, e.evc);
            end
            results++;
        end
    end

    initial begin : g_ready
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            i_ready <= 1;
        end
    end

    initial begin : g_limit
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_cmd(t_req r, bit check_fixed, t_rsp fixed);
        t_rsp p;
        if (!no_idle && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        req <= r;
        i_valid <= 1;
        p = predict_cache(r);
        if (r.cmd == CMD_PUT && r.hnd != 0) n_put++;
        if (p.hit) n_hit++;
        n_evicted += p.evc;
        if (check_fixed && p !== fixed) begin
            $display("model disagrees with directed row for command %0d", r.cmd);
            errors++;
        end
        expected_rsp.push_back(p);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic write_budget(logic [31:0] v);
        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (TAIL_OFF) @(negedge i_clk);
        i_max_bytes <= v;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        m_budget = v;
    endtask

    function automatic t_req mk(logic [2:0] c, logic [7:0] s, logic [23:0] x,
                                logic [31:0] hd, logic [12:0] w, logic [12:0] h,
                                logic [31:0] tg);
        t_req r;
        r = '{cmd: c, sch: s, zm: 5'(x % 25), tx: x, ty: x ^ 24'h5a5a5a,
              hnd: hd, w: w, h: h, tgt: tg};
        return r;
    endfunction

    function automatic t_req rand_req(int pool);
        t_req r;
        int u;
        r.sch = 8'($urandom_range(0, pool));
        r.zm  = 5'($urandom_range(0, 1));
        r.tx  = 24'($urandom_range(0, pool));
        r.ty  = 24'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            r.sch = 8'($urandom); r.zm = 5'($urandom_range(0, 31));
            r.tx = 24'($urandom); r.ty = 24'($urandom);
        end
        u = $urandom_range(0, 99);
        r.cmd = u < 30 ? CMD_GET : u < 70 ? CMD_PUT : u < 85 ? CMD_CONTAINS :
                u < 94 ? CMD_EVICT : u < 97 ? CMD_CLEAR : 3'($urandom_range(5, 7));
        r.hnd = $urandom_range(0, 15) == 0 ? 32'd0 : $urandom;
        r.w   = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 64));
        r.h   = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 64));
        r.tgt = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000);
        return r;
    endfunction

    t_req dir_req [$];
    t_rsp dir_rsp [$];
    bit   dir_fix [$];

    initial begin
        t_req r;
        errors = 0; results = 0; cycles = 0; no_idle = 0;
        n_put = 0; n_hit = 0; n_evicted = 0;
        m_total = '0;
        m_budget = 32'd268435456;
        for (int i = 0; i < ENTRIES; i++) m_valid[i] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed table: a fixed expectation for every row, also checked against the model
        dir_req = '{
            mk(CMD_GET,      8'd1, 24'd1, 32'd0,          13'd0,    13'd0,    32'd0),
            mk(CMD_PUT,      8'd1, 24'd1, 32'd0,          13'd4,    13'd4,    32'd0),
            mk(CMD_PUT,      8'd1, 24'd1, 32'hffffffff,   13'd4,    13'd4,    32'd0),
            mk(CMD_GET,      8'd1, 24'd1, 32'd0,          13'd0,    13'd0,    32'd0),
            mk(CMD_PUT,      8'd1, 24'd1, 32'd7,          13'd2,    13'd2,    32'd0),
            mk(CMD_PUT,      8'hff, 24'hffffff, 32'd9,    13'd0,    13'd100,  32'd0),
            mk(CMD_CONTAINS, 8'hff, 24'hffffff, 32'd0,    13'd0,    13'd0,    32'd0),
            mk(CMD_PUT,      8'd3, 24'd3, 32'd3,          13'd8191, 13'd8191, 32'd0),
            mk(CMD_PUT,      8'd4, 24'd4, 32'd4,          13'd4096, 13'd4096, 32'd0),
            mk(CMD_EVICT,    8'd0, 24'd0, 32'd0,          13'd0,    13'd0,    32'hffffffff),
            mk(CMD_EVICT,    8'd0, 24'd0, 32'd0,          13'd0,    13'd0,    32'd0),
            mk(CMD_PUT,      8'd5, 24'd5, 32'd5,          13'd1,    13'd1,    32'd0),
            mk(3'd7,         8'd5, 24'd5, 32'd5,          13'd1,    13'd1,    32'd5),
            mk(3'd5,         8'd5, 24'd5, 32'd5,          13'd1,    13'd1,    32'd5),
            mk(CMD_CLEAR,    8'd0, 24'd0, 32'd0,          13'd0,    13'd0,    32'd0)
        };
        dir_rsp = '{
            '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 64, 0}, '{1, 32'hffffffff, 64, 0},
            '{0, 0, 16, 1}, '{0, 0, 16, 0}, '{1, 0, 16, 0}, '{0, 0, 34'd268369940, 0},
            '{0, 0, 34'd67108864, 3}, '{0, 0, 34'd67108864, 0}, '{0, 0, 0, 1},
            '{0, 0, 4, 0}, '{0, 0, 4, 0}, '{0, 0, 4, 0}, '{0, 0, 0, 0}
        };
        dir_fix = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
        foreach (dir_req[i]) send_cmd(dir_req[i], dir_fix[i], dir_rsp[i]);

        // table fill beyond capacity
        for (int i = 0; i < ENTRIES + 3; i++)
            send_cmd(mk(CMD_PUT, 8'd9, 24'(i), 32'(i + 1), 13'd1, 13'd1, 0), 0, '0);

        for (int i = 0; i < N_RAND; i++) begin
            case (i)
                0:   write_budget(32'd0);
                150: write_budget(32'd20000);
                350: write_budget(32'hffffffff);
                550: write_budget(32'd4000);
                650: begin
                    while (expected_rsp.size() != 0) @(negedge i_clk);
                    write_budget(32'd268435456);
                end
                750: no_idle = 1;
                default: ;
            endcase
            r = rand_req(i < 350 ? 12 : 90);
            send_cmd(r, 0, '0);
        end

        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (TAIL_OFF) @(negedge i_clk);
        $display("covered %0d results, %0d stored tiles, %0d hits, %0d evictions",
                 results, n_put, n_hit, n_evicted);
        $display("budgets swept from zero to full range, including table-full and oversize");
        if (errors == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
